/* sv/hecb_pkg.sv */
// Shared constants, types and state codes of the half-edge connectivity builder.
package hecb_pkg;

    localparam int VTX_W         = 16;
    localparam int ID_W          = 12;
    localparam int FACE_W        = 16;
    localparam int EDGE_CAPACITY = 4096;
    localparam int ADDR_W        = $clog2(EDGE_CAPACITY);
    localparam int HEC_W         = ADDR_W + 1;
    localparam int FACE_LIMIT    = 65536;
    localparam int FCNT_W        = $clog2(FACE_LIMIT) + 1;
    localparam int HASH_SHIFT    = 17;
    localparam int HASH_W        = ADDR_W + HASH_SHIFT;

    localparam logic [31:0] HASH_K1 = 32'h9E3779B1;
    localparam logic [31:0] HASH_K2 = 32'h85EBCA77;

    typedef struct packed {
        logic              valid;
        logic [VTX_W-1:0]  u;
        logic [VTX_W-1:0]  v;
        logic [ADDR_W-1:0] id;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        t_entry            wdata;
    } t_tab_req;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LSTART,
        S_LHASH,
        S_LREAD,
        S_LCMP,
        S_EVAL,
        S_ISEL,
        S_IHASH,
        S_IREAD,
        S_ICMP,
        S_OUT
    } t_state;

endpackage

/* sv/hecb_tri_if.sv */
// Triangle input channel: three vertex indices with valid/ready.
interface hecb_tri_if;
    logic                      valid;
    logic                      ready;
    logic [hecb_pkg::VTX_W-1:0] vertex_a;
    logic [hecb_pkg::VTX_W-1:0] vertex_b;
    logic [hecb_pkg::VTX_W-1:0] vertex_c;

    modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                    input ready);
    modport sink   (input valid, input vertex_a, input vertex_b, input vertex_c,
                    output ready);
endinterface

/* sv/hecb_rec_if.sv */
// Half-edge record output channel with valid/ready.
interface hecb_rec_if;
    logic                        valid;
    logic                        ready;
    logic [hecb_pkg::ID_W-1:0]   edge_id;
    logic [hecb_pkg::ID_W-1:0]   twin_id;
    logic [hecb_pkg::VTX_W-1:0]  origin_vertex;
    logic [hecb_pkg::FACE_W-1:0] face_number;
    logic [hecb_pkg::ID_W-1:0]   next_id;
    logic [hecb_pkg::ID_W-1:0]   prev_id;
    logic                        created_new;
    logic                        overflow_error;
    logic                        last_of_face;

    modport source (output valid, output edge_id, output twin_id, output origin_vertex,
                    output face_number, output next_id, output prev_id,
                    output created_new, output overflow_error, output last_of_face,
                    input ready);
    modport sink   (input valid, input edge_id, input twin_id, input origin_vertex,
                    input face_number, input next_id, input prev_id,
                    input created_new, input overflow_error, input last_of_face,
                    output ready);
endinterface

/* sv/hecb_hash.sv */
// Edge-table slot hash on one shared multiplier, two products computed in turn.
module hecb_hash (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hecb_pkg::VTX_W-1:0]    i_u,
    input  logic [hecb_pkg::VTX_W-1:0]    i_v,
    output logic                          o_done,
    output logic [hecb_pkg::ADDR_W-1:0]   o_slot
);
    localparam int PW = hecb_pkg::VTX_W + hecb_pkg::HASH_W;

    logic                         r_busy;
    logic                         r_done;
    logic [hecb_pkg::VTX_W-1:0]   r_v;
    logic [hecb_pkg::HASH_W-1:0]  r_acc;
    logic [hecb_pkg::VTX_W-1:0]   w_a;
    logic [hecb_pkg::HASH_W-1:0]  w_k;
    logic [PW-1:0]                w_full;
    logic [hecb_pkg::HASH_W-1:0]  w_prod;

    assign w_a    = r_busy ? r_v : i_u;
    assign w_k    = r_busy ? hecb_pkg::HASH_K2[hecb_pkg::HASH_W-1:0]
                           : hecb_pkg::HASH_K1[hecb_pkg::HASH_W-1:0];
    assign w_full = PW'(w_a) * PW'(w_k);
    assign w_prod = w_full[hecb_pkg::HASH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_acc  <= r_acc ^ w_prod;
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (i_start) begin
                r_acc  <= w_prod;
                r_v    <= i_v;
                r_busy <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_slot = r_acc[hecb_pkg::ADDR_W-1:0]
                  ^ r_acc[hecb_pkg::HASH_W-1 -: hecb_pkg::ADDR_W];
endmodule

/* sv/hecb_table.sv */
// Edge table memory: one write and one registered read per cycle, both at the request address.
module hecb_table (
    input  logic                i_clk,
    input  hecb_pkg::t_tab_req  i_req,
    output hecb_pkg::t_entry    o_rdata
);
    hecb_pkg::t_entry r_mem [hecb_pkg::EDGE_CAPACITY];
    hecb_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/half_edge_connectivity_builder.sv */
// Top level: sequencer that builds half-edge links per triangle over a hashed edge table.
//
//  channel | dir | payload                                           | accepted when
//  i_tri   | in  | vertex_a, vertex_b, vertex_c                      | valid & ready
//  o_rec   | out | edge/twin/next/prev ids, origin, face, flags      | valid & ready
//
// After reset a clearing pass writes every table entry invalid; no input is taken during it.
// Per face: an accept step, three lookups (hash, then read and compare per probe), an evaluate step,
// a select step per side without a new pair, two inserts per new twin pair (hash, then read and compare
// per probe), then three output transactions; a rejected face skips the select and insert steps.
// Lookups and inserts share one hash multiplier, and all table accesses use the single table port.
// Output stalls hold the block; a new triangle is taken only after the third record leaves.
module half_edge_connectivity_builder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hecb_tri_if.sink   i_tri,
    hecb_rec_if.source o_rec
);
    localparam int AW = hecb_pkg::ADDR_W;
    localparam int HW = hecb_pkg::HEC_W;

    function automatic int nx(input int k);
        return (k == 2) ? 0 : k + 1;
    endfunction

    hecb_pkg::t_state              r_state, n_state;
    logic [AW-1:0]                 r_clr;
    logic [hecb_pkg::VTX_W-1:0]    r_vx [3];
    logic [1:0]                    r_k;
    logic [AW-1:0]                 r_addr;
    logic [AW-1:0]                 r_probe;
    logic [2:0]                    r_found;
    logic [AW-1:0]                 r_fid [3];
    logic [2:0]                    r_made;
    logic [AW-1:0]                 r_eid [3];
    logic                          r_rej;
    logic [HW-1:0]                 r_hec;
    logic [hecb_pkg::FCNT_W-1:0]   r_fcnt;
    logic [hecb_pkg::FACE_W-1:0]   r_face;
    logic                          r_ins_hi;
    logic [1:0]                    r_out_k;

    hecb_pkg::t_tab_req            w_req;
    hecb_pkg::t_entry              w_rdata;
    logic                          w_hstart;
    logic                          w_hdone;
    logic [AW-1:0]                 w_slot;
    logic [1:0]                    w_kn;
    logic [hecb_pkg::VTX_W-1:0]    w_key_u;
    logic [hecb_pkg::VTX_W-1:0]    w_key_v;
    logic                          w_hit;

    logic [2:0]                    w_made;
    logic [AW-1:0]                 w_eid [3];
    logic [HW:0]                   w_base;
    logic                          w_rej;

    hecb_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hstart),
        .i_u     (w_key_u),
        .i_v     (w_key_v),
        .o_done  (w_hdone),
        .o_slot  (w_slot)
    );

    hecb_table u_table (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign w_kn    = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
    assign w_key_u = r_ins_hi ? r_vx[w_kn] : r_vx[r_k];
    assign w_key_v = r_ins_hi ? r_vx[r_k]  : r_vx[w_kn];
    assign w_hit   = w_rdata.valid && (w_rdata.u == w_key_u) && (w_rdata.v == w_key_v);

    // face evaluation: which sides need a new twin pair, ids, and overflow
    always_comb begin
        logic          v_seen;
        logic          v_rev;
        logic          v_same;
        logic [AW-1:0] v_src;
        w_made = '0;
        w_base = {1'b0, r_hec};
        for (int k = 0; k < 3; k++) begin
            v_seen = r_found[k];
            v_src  = '0;
            for (int j = 0; j < k; j++) begin
                v_rev  = (r_vx[nx(k)] == r_vx[j]) && (r_vx[k] == r_vx[nx(j)]);
                v_same = (r_vx[k] == r_vx[j]) && (r_vx[nx(k)] == r_vx[nx(j)]);
                if (w_made[j] && (v_rev || v_same)) begin
                    v_seen = 1'b1;
                    v_src  = w_eid[j] + AW'(v_rev);
                end
            end
            w_made[k] = !v_seen;
            if (r_found[k]) begin
                w_eid[k] = r_fid[k];
            end else if (!v_seen) begin
                w_eid[k] = w_base[AW-1:0];
            end else begin
                w_eid[k] = v_src;
            end
            if (!v_seen) begin
                w_base = w_base + (HW+1)'(2);
            end
        end
        w_rej = (r_fcnt >= hecb_pkg::FCNT_W'(hecb_pkg::FACE_LIMIT))
             || (w_base > (HW+1)'(hecb_pkg::EDGE_CAPACITY));
    end

    always_comb begin
        n_state  = r_state;
        w_hstart = 1'b0;
        w_req    = '0;
        w_req.addr = r_addr;
        unique case (r_state)
            hecb_pkg::S_CLEAR: begin
                w_req.we   = 1'b1;
                w_req.addr = r_clr;
                if (r_clr == '1) n_state = hecb_pkg::S_IDLE;
            end
            hecb_pkg::S_IDLE: begin
                if (i_tri.valid) n_state = hecb_pkg::S_LSTART;
            end
            hecb_pkg::S_LSTART: begin
                w_hstart = 1'b1;
                n_state  = hecb_pkg::S_LHASH;
            end
            hecb_pkg::S_LHASH: begin
                if (w_hdone) n_state = hecb_pkg::S_LREAD;
            end
            hecb_pkg::S_LREAD: begin
                w_req.re = 1'b1;
                n_state  = hecb_pkg::S_LCMP;
            end
            hecb_pkg::S_LCMP: begin
                if (!w_rdata.valid || w_hit || r_probe == '1) begin
                    n_state = (r_k == 2'd2) ? hecb_pkg::S_EVAL : hecb_pkg::S_LSTART;
                end else begin
                    n_state = hecb_pkg::S_LREAD;
                end
            end
            hecb_pkg::S_EVAL: begin
                n_state = w_rej ? hecb_pkg::S_OUT : hecb_pkg::S_ISEL;
            end
            hecb_pkg::S_ISEL: begin
                if (r_made[r_k]) begin
                    w_hstart = 1'b1;
                    n_state  = hecb_pkg::S_IHASH;
                end else if (r_k == 2'd2) begin
                    n_state = hecb_pkg::S_OUT;
                end
            end
            hecb_pkg::S_IHASH: begin
                if (w_hdone) n_state = hecb_pkg::S_IREAD;
            end
            hecb_pkg::S_IREAD: begin
                w_req.re = 1'b1;
                n_state  = hecb_pkg::S_ICMP;
            end
            hecb_pkg::S_ICMP: begin
                if (!w_rdata.valid || w_hit) begin
                    w_req.we          = 1'b1;
                    w_req.wdata.valid = 1'b1;
                    w_req.wdata.u     = w_key_u;
                    w_req.wdata.v     = w_key_v;
                    w_req.wdata.id    = r_eid[r_k] + AW'(r_ins_hi);
                    if (r_ins_hi && r_k == 2'd2) begin
                        n_state = hecb_pkg::S_OUT;
                    end else begin
                        n_state = hecb_pkg::S_ISEL;
                    end
                end else begin
                    n_state = hecb_pkg::S_IREAD;
                end
            end
            hecb_pkg::S_OUT: begin
                if (o_rec.ready && r_out_k == 2'd2) n_state = hecb_pkg::S_IDLE;
            end
            default: n_state = hecb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hecb_pkg::S_CLEAR;
            r_clr    <= '0;
            r_hec    <= '0;
            r_fcnt   <= '0;
            r_k      <= '0;
            r_ins_hi <= 1'b0;
            r_out_k  <= '0;
            r_rej    <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                hecb_pkg::S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                end
                hecb_pkg::S_IDLE: begin
                    if (i_tri.valid) begin
                        r_vx[0]  <= i_tri.vertex_a;
                        r_vx[1]  <= i_tri.vertex_b;
                        r_vx[2]  <= i_tri.vertex_c;
                        r_k      <= '0;
                        r_ins_hi <= 1'b0;
                    end
                end
                hecb_pkg::S_LHASH, hecb_pkg::S_IHASH: begin
                    if (w_hdone) begin
                        r_addr  <= w_slot;
                        r_probe <= '0;
                    end
                end
                hecb_pkg::S_LCMP: begin
                    if (!w_rdata.valid || w_hit || r_probe == '1) begin
                        r_found[r_k] <= w_hit;
                        r_fid[r_k]   <= w_rdata.id;
                        r_k          <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    end else begin
                        r_addr  <= r_addr + AW'(1);
                        r_probe <= r_probe + AW'(1);
                    end
                end
                hecb_pkg::S_EVAL: begin
                    r_made   <= w_made;
                    r_rej    <= w_rej;
                    r_face   <= r_fcnt[hecb_pkg::FACE_W-1:0];
                    r_k      <= '0;
                    r_ins_hi <= 1'b0;
                    r_out_k  <= '0;
                    for (int k = 0; k < 3; k++) r_eid[k] <= w_eid[k];
                    if (!w_rej) begin
                        r_hec  <= w_base[HW-1:0];
                        r_fcnt <= r_fcnt + hecb_pkg::FCNT_W'(1);
                    end
                end
                hecb_pkg::S_ISEL: begin
                    if (!r_made[r_k] && r_k != 2'd2) r_k <= r_k + 2'd1;
                end
                hecb_pkg::S_ICMP: begin
                    if (!w_rdata.valid || w_hit) begin
                        r_ins_hi <= !r_ins_hi;
                        if (r_ins_hi && r_k != 2'd2) r_k <= r_k + 2'd1;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                hecb_pkg::S_OUT: begin
                    if (o_rec.ready) r_out_k <= (r_out_k == 2'd2) ? 2'd0 : r_out_k + 2'd1;
                end
                default: begin end
            endcase
        end
    end

    assign i_tri.ready = (r_state == hecb_pkg::S_IDLE);

    always_comb begin
        logic [1:0] v_n;
        logic [1:0] v_p;
        v_n = (r_out_k == 2'd2) ? 2'd0 : r_out_k + 2'd1;
        v_p = (r_out_k == 2'd0) ? 2'd2 : r_out_k - 2'd1;
        o_rec.valid          = (r_state == hecb_pkg::S_OUT);
        o_rec.origin_vertex  = r_vx[r_out_k];
        o_rec.overflow_error = r_rej;
        o_rec.last_of_face   = (r_out_k == 2'd2);
        if (r_rej) begin
            o_rec.edge_id     = '0;
            o_rec.twin_id     = '0;
            o_rec.face_number = '0;
            o_rec.next_id     = '0;
            o_rec.prev_id     = '0;
            o_rec.created_new = 1'b0;
        end else begin
            o_rec.edge_id     = hecb_pkg::ID_W'(r_eid[r_out_k]);
            o_rec.twin_id     = hecb_pkg::ID_W'(r_eid[r_out_k] ^ AW'(1));
            o_rec.face_number = r_face;
            o_rec.next_id     = hecb_pkg::ID_W'(r_eid[v_n]);
            o_rec.prev_id     = hecb_pkg::ID_W'(r_eid[v_p]);
            o_rec.created_new = r_made[r_out_k];
        end
    end
endmodule
